// ===== sv/md4_pkg.sv =====
package md4_pkg;

  // Initial chaining words A, B, C, D
  localparam logic [31:0] IV [4] = '{32'h67452301, 32'hefcdab89, 32'h98badcfe, 32'h10325476};

  localparam logic [31:0] K_ROUND2 = 32'h5a827999;
  localparam logic [31:0] K_ROUND3 = 32'h6ed9eba1;
  localparam logic [7:0]  PAD_BYTE = 8'h80;
  localparam logic [5:0]  LAST_POS = 6'h3f;
  localparam logic [5:0]  LAST_RND = 6'd47;
  localparam logic [3:0]  LEN_LO_WORD = 4'd14;
  localparam logic [3:0]  LEN_HI_WORD = 4'd15;
  localparam logic [4:0]  WORDS_PER_BLOCK = 5'd16;

  typedef logic [3:0] step_t;

  // Microprogram addresses
  localparam step_t ST_WAIT  = 4'd0;
  localparam step_t ST_LOAD  = 4'd1;
  localparam step_t ST_ROUND = 4'd2;
  localparam step_t ST_ADD   = 4'd3;
  localparam step_t ST_PAD   = 4'd4;
  localparam step_t ST_CLR   = 4'd5;
  localparam step_t ST_SPLIT = 4'd6;
  localparam step_t ST_REARM = 4'd7;
  localparam step_t ST_LENLO = 4'd8;
  localparam step_t ST_LENHI = 4'd9;
  localparam step_t ST_FINAL = 4'd10;
  localparam step_t ST_EMIT  = 4'd11;
  localparam step_t ST_INIT  = 4'd12;

  typedef enum logic [3:0] {
    OP_WAIT,   // take a word; alt = compress, nxt = finalize
    OP_LOAD,   // working regs from chain
    OP_ROUND,  // one round per cycle, falls through after the last
    OP_ADD,    // fold into chain, return
    OP_PAD,    // write the word holding the 0x80 marker
    OP_CLR,    // zero words up to the end; alt when a second block is needed
    OP_CALL,   // return to nxt, jump to alt
    OP_REARM,  // restart the clear sweep from word 0
    OP_LENLO,
    OP_LENHI,
    OP_EMIT,
    OP_INIT
  } op_t;

  typedef struct packed {
    op_t   op;
    step_t nxt;
    step_t alt;
  } uword_t;

  function automatic uword_t ucode(step_t pc);
    uword_t u;
    unique case (pc)
      ST_WAIT:  u = '{OP_WAIT,  ST_PAD,   ST_LOAD};
      ST_LOAD:  u = '{OP_LOAD,  ST_ROUND, ST_ROUND};
      ST_ROUND: u = '{OP_ROUND, ST_ADD,   ST_ROUND};
      ST_ADD:   u = '{OP_ADD,   ST_WAIT,  ST_WAIT};
      ST_PAD:   u = '{OP_PAD,   ST_CLR,   ST_CLR};
      ST_CLR:   u = '{OP_CLR,   ST_LENLO, ST_SPLIT};
      ST_SPLIT: u = '{OP_CALL,  ST_REARM, ST_LOAD};
      ST_REARM: u = '{OP_REARM, ST_CLR,   ST_CLR};
      ST_LENLO: u = '{OP_LENLO, ST_LENHI, ST_LENHI};
      ST_LENHI: u = '{OP_LENHI, ST_FINAL, ST_FINAL};
      ST_FINAL: u = '{OP_CALL,  ST_EMIT,  ST_LOAD};
      ST_EMIT:  u = '{OP_EMIT,  ST_INIT,  ST_INIT};
      ST_INIT:  u = '{OP_INIT,  ST_WAIT,  ST_WAIT};
      default:  u = '{OP_INIT,  ST_WAIT,  ST_WAIT};
    endcase
    return u;
  endfunction

  // Message word used by a round
  function automatic logic [3:0] word_sel(logic [5:0] rnd);
    logic [3:0] w;
    unique case (rnd[5:4])
      2'd0:    w = rnd[3:0];
      2'd1:    w = {rnd[1:0], rnd[3:2]};
      default: w = {rnd[0], rnd[1], rnd[2], rnd[3]};
    endcase
    return w;
  endfunction

  // Rotate amount, indexed by {stage, round mod 4}
  function automatic logic [4:0] rot_amt(logic [3:0] idx);
    logic [4:0] s;
    unique case (idx)
      4'd0:    s = 5'd3;
      4'd1:    s = 5'd7;
      4'd2:    s = 5'd11;
      4'd3:    s = 5'd19;
      4'd4:    s = 5'd3;
      4'd5:    s = 5'd5;
      4'd6:    s = 5'd9;
      4'd7:    s = 5'd13;
      4'd8:    s = 5'd3;
      4'd9:    s = 5'd9;
      4'd10:   s = 5'd11;
      4'd11:   s = 5'd15;
      default: s = 5'd3;
    endcase
    return s;
  endfunction

endpackage

// ===== sv/md4_message_digest.sv =====
// MD4 digest engine over a byte stream.
// Input channel (in_valid / in_stall): one word per item carrying data_byte,
// has_byte and message_end. A byte is packed little-endian into the 16-word
// block. Items with has_byte low and message_end low are no-ops.
// Output channel (out_valid / out_stall): four words per message, digest_word
// with word_index 0..3, digest_last on index 3; word 0 low byte comes first.
// Sequence: a byte that does not close a block leaves the sequencer waiting.
// A byte that closes a 64-byte block stalls the input for the load, 48
// rounds through the single round unit and the fold. At message end: the
// pad step, a clear of the remaining block words, and when fewer than 8
// bytes are left for the length an extra compression and a clear of the
// whole block; then the two length words and the call, the compression,
// the emit of the four digest words and the reinitialise step.
// A stalled output holds its word and the sequencer waits in the emit step;
// the input stays stalled until all four words are loaded out.
// Reset (rst, synchronous) loads the initial chaining words, clears the bit
// count and returns the sequencer to its wait step with no output pending.
module md4_message_digest (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  data_byte,
  input  logic        has_byte,
  input  logic        message_end,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] digest_word,
  output logic [1:0]  word_index,
  output logic        digest_last
);

  md4_pkg::step_t  pc;
  md4_pkg::step_t  ret_pc;
  md4_pkg::uword_t ctl;

  logic [31:0] chain [4];
  logic [31:0] mb [16];
  logic [63:0] bit_count;
  logic [31:0] pack;
  logic [31:0] a, b, c, d;
  logic [5:0]  rnd;
  logic [4:0]  clr;
  logic        fin_two;
  logic [1:0]  widx;

  logic        in_accept;
  logic [5:0]  pos;
  logic [31:0] pack_new;
  logic [31:0] pad_word;
  logic        mb_we;
  logic [3:0]  mb_wa;
  logic [31:0] mb_wd;
  logic [31:0] f, k, t, rot;
  logic [63:0] rot_wide;
  logic [4:0]  s;
  logic        out_take;

  assign ctl       = md4_pkg::ucode(pc);
  assign in_stall  = (pc != md4_pkg::ST_WAIT);
  assign in_accept = in_valid && !in_stall;
  assign out_take  = out_valid && !out_stall;
  assign pos       = bit_count[8:3];

  // Byte lane packing; a lane-0 byte clears the upper lanes
  always_comb begin
    if (pos[1:0] == 2'd0) begin
      pack_new = {24'd0, data_byte};
      pad_word = {24'd0, md4_pkg::PAD_BYTE};
    end else begin
      pack_new = pack | ({24'd0, data_byte} << {pos[1:0], 3'b000});
      pad_word = pack | ({24'd0, md4_pkg::PAD_BYTE} << {pos[1:0], 3'b000});
    end
  end

  always_comb begin
    mb_we = 1'b0;
    mb_wa = pos[5:2];
    mb_wd = pack_new;
    unique case (ctl.op)
      md4_pkg::OP_WAIT: begin
        mb_we = in_accept && has_byte && (pos[1:0] == 2'd3);
      end
      md4_pkg::OP_PAD: begin
        mb_we = 1'b1;
        mb_wd = pad_word;
      end
      md4_pkg::OP_CLR: begin
        mb_we = (clr != md4_pkg::WORDS_PER_BLOCK);
        mb_wa = clr[3:0];
        mb_wd = '0;
      end
      md4_pkg::OP_LENLO: begin
        mb_we = 1'b1;
        mb_wa = md4_pkg::LEN_LO_WORD;
        mb_wd = bit_count[31:0];
      end
      md4_pkg::OP_LENHI: begin
        mb_we = 1'b1;
        mb_wa = md4_pkg::LEN_HI_WORD;
        mb_wd = bit_count[63:32];
      end
      default: mb_we = 1'b0;
    endcase
  end

  // Round unit
  always_comb begin
    unique case (rnd[5:4])
      2'd0: begin
        f = (b & c) | (~b & d);
        k = '0;
      end
      2'd1: begin
        f = (b & c) | (b & d) | (c & d);
        k = md4_pkg::K_ROUND2;
      end
      default: begin
        f = b ^ c ^ d;
        k = md4_pkg::K_ROUND3;
      end
    endcase
    s        = md4_pkg::rot_amt({rnd[5:4], rnd[1:0]});
    t        = a + f + mb[md4_pkg::word_sel(rnd)] + k;
    rot_wide = {t, t} << s;
    rot      = rot_wide[63:32];
  end

  always_ff @(posedge clk) begin
    if (mb_we) begin
      mb[mb_wa] <= mb_wd;
    end
    if (in_accept && has_byte) begin
      pack <= pack_new;
    end
    if (ctl.op == md4_pkg::OP_LOAD) begin
      a <= chain[0];
      b <= chain[1];
      c <= chain[2];
      d <= chain[3];
    end else if (ctl.op == md4_pkg::OP_ROUND) begin
      a <= d;
      d <= c;
      c <= b;
      b <= rot;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc          <= md4_pkg::ST_WAIT;
      ret_pc      <= md4_pkg::ST_WAIT;
      chain       <= md4_pkg::IV;
      bit_count   <= '0;
      rnd         <= '0;
      clr         <= '0;
      fin_two     <= 1'b0;
      widx        <= '0;
      out_valid   <= 1'b0;
      digest_word <= '0;
      word_index  <= '0;
      digest_last <= 1'b0;
    end else begin
      if (out_take) begin
        out_valid <= 1'b0;
      end
      unique case (ctl.op)
        md4_pkg::OP_WAIT: begin
          if (in_accept) begin
            if (has_byte) begin
              bit_count <= bit_count + 64'd8;
            end
            if (has_byte && pos == md4_pkg::LAST_POS) begin
              ret_pc <= message_end ? ctl.nxt : md4_pkg::ST_WAIT;
              pc     <= ctl.alt;
            end else if (message_end) begin
              pc <= ctl.nxt;
            end
          end
        end
        md4_pkg::OP_LOAD: begin
          rnd <= '0;
          pc  <= ctl.nxt;
        end
        md4_pkg::OP_ROUND: begin
          rnd <= rnd + 6'd1;
          pc  <= (rnd == md4_pkg::LAST_RND) ? ctl.nxt : ctl.alt;
        end
        md4_pkg::OP_ADD: begin
          chain[0] <= chain[0] + a;
          chain[1] <= chain[1] + b;
          chain[2] <= chain[2] + c;
          chain[3] <= chain[3] + d;
          pc       <= ret_pc;
        end
        md4_pkg::OP_PAD: begin
          clr     <= {1'b0, pos[5:2]} + 5'd1;
          fin_two <= (pos[5:3] == 3'b111);
          pc      <= ctl.nxt;
        end
        md4_pkg::OP_CLR: begin
          if (clr == md4_pkg::WORDS_PER_BLOCK) begin
            pc <= fin_two ? ctl.alt : ctl.nxt;
          end else begin
            clr <= clr + 5'd1;
          end
        end
        md4_pkg::OP_CALL: begin
          ret_pc <= ctl.nxt;
          pc     <= ctl.alt;
        end
        md4_pkg::OP_REARM: begin
          clr     <= '0;
          fin_two <= 1'b0;
          pc      <= ctl.nxt;
        end
        md4_pkg::OP_LENLO, md4_pkg::OP_LENHI: begin
          pc <= ctl.nxt;
        end
        md4_pkg::OP_EMIT: begin
          if (!out_valid || out_take) begin
            out_valid   <= 1'b1;
            digest_word <= chain[widx];
            word_index  <= widx;
            digest_last <= (widx == 2'd3);
            widx        <= widx + 2'd1;
            if (widx == 2'd3) begin
              pc <= ctl.nxt;
            end
          end
        end
        md4_pkg::OP_INIT: begin
          chain     <= md4_pkg::IV;
          bit_count <= '0;
          pc        <= ctl.nxt;
        end
        default: pc <= md4_pkg::ST_WAIT;
      endcase
    end
  end

  a_words_in_order: assert property (@(posedge clk) disable iff (rst)
    out_take && !digest_last |=> out_valid && word_index == $past(word_index) + 2'd1)
    else $error("digest words not delivered in sequence");

  a_last_flag: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> digest_last == (word_index == 2'd3))
    else $error("digest_last does not match word_index");

  a_byte_aligned: assert property (@(posedge clk) disable iff (rst)
    bit_count[2:0] == 3'd0)
    else $error("bit count lost byte alignment");

  a_clr_bound: assert property (@(posedge clk) disable iff (rst)
    pc == md4_pkg::ST_CLR |-> clr <= md4_pkg::WORDS_PER_BLOCK)
    else $error("clear sweep ran past the block");

  a_round_bound: assert property (@(posedge clk) disable iff (rst)
    pc == md4_pkg::ST_ROUND |-> rnd <= md4_pkg::LAST_RND)
    else $error("round counter out of range");

endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;

  typedef struct packed {
    logic [7:0] data;
    logic       has;
    logic       fin;
  } byte_item_t;

  typedef struct packed {
    logic [31:0] word;
    logic [1:0]  idx;
    logic        last;
  } digest_out_t;

  localparam int ITEM_TARGET = 210;
  localparam int MAX_WAIT = 12;
  localparam int HOLD_CYCLES = 2000;
  localparam int HOLD_AFTER_WORDS = 24;
  localparam int DRAIN_CYCLES = 200;

  localparam logic [31:0] CHAIN_INIT [4] =
    '{32'h67452301, 32'hefcdab89, 32'h98badcfe, 32'h10325476};
  localparam logic [31:0] ROUND2_ADD = 32'h5a827999;
  localparam logic [31:0] ROUND3_ADD = 32'h6ed9eba1;
  localparam logic [7:0]  PAD_MARK = 8'h80;
  localparam int SHIFT_F [4] = '{3, 7, 11, 19};
  localparam int SHIFT_G [4] = '{3, 5, 9, 13};
  localparam int SHIFT_H [4] = '{3, 9, 11, 15};
  localparam int H_ORDER [16] = '{0, 8, 4, 12, 2, 10, 6, 14, 1, 9, 5, 13, 3, 11, 7, 15};

  logic        clk;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  data_byte = 8'h00;
  logic        has_byte = 1'b0;
  logic        message_end = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [31:0] digest_word;
  logic [1:0]  word_index;
  logic        digest_last;

  md4_message_digest i_dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .data_byte   (data_byte),
    .has_byte    (has_byte),
    .message_end (message_end),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .digest_word (digest_word),
    .word_index  (word_index),
    .digest_last (digest_last)
  );

  byte_item_t  pending_bytes [$];
  digest_out_t digest_expect [$];
  int          items_queued = 0;
  int          errors = 0;
  int          words_seen = 0;

  // predictor state
  logic [31:0] chain [4];
  logic [31:0] blk [16];
  logic [63:0] msg_bits;

  bit in_taken = 1'b0;
  bit out_taken = 1'b0;
  int gap_left = 0;
  int calm_in = 0;
  int stall_left = 0;
  int calm_out = 0;
  int hold_left = 0;
  bit hold_done = 1'b0;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic int draw_pause(inout int calm);
    int n;
    if (calm > 0) begin
      calm--;
      n = 0;
    end else begin
      n = $urandom_range(0, MAX_WAIT);
      // occasional stretch with no idling at all
      if ($urandom_range(0, 15) == 0) calm = $urandom_range(10, 40);
    end
    return n;
  endfunction

  function automatic void md4_compress();
    logic [31:0] a, b, c, d, f, k, t, n;
    int i, j, w, s;
    a = chain[0];
    b = chain[1];
    c = chain[2];
    d = chain[3];
    for (i = 0; i < 48; i++) begin
      j = i % 16;
      case (i / 16)
        0: begin
          f = (b & c) | (~b & d);
          k = '0;
          w = j;
          s = SHIFT_F[j % 4];
        end
        1: begin
          f = (b & c) | (b & d) | (c & d);
          k = ROUND2_ADD;
          w = (j % 4) * 4 + j / 4;
          s = SHIFT_G[j % 4];
        end
        default: begin
          f = b ^ c ^ d;
          k = ROUND3_ADD;
          w = H_ORDER[j];
          s = SHIFT_H[j % 4];
        end
      endcase
      t = a + f + blk[w] + k;
      n = (t << s) | (t >> (32 - s));
      a = d;
      d = c;
      c = b;
      b = n;
    end
    chain[0] += a;
    chain[1] += b;
    chain[2] += c;
    chain[3] += d;
  endfunction

  function automatic void store_byte(logic [5:0] pos, logic [7:0] v);
    // first byte of a word clears its upper lanes
    if (pos[1:0] == 2'd0) blk[pos[5:2]] = {24'h0, v};
    else blk[pos[5:2]][pos[1:0] * 8 +: 8] = v;
  endfunction

  function automatic void restart_digest();
    for (int i = 0; i < 4; i++) chain[i] = CHAIN_INIT[i];
    msg_bits = '0;
  endfunction

  function automatic void digest_absorb(logic [7:0] v, logic has, logic fin);
    logic [5:0] pos;
    digest_out_t e;
    if (has) begin
      pos = msg_bits[8:3];
      store_byte(pos, v);
      msg_bits += 64'd8;
      if (pos == 6'd63) md4_compress();
    end
    if (fin) begin
      pos = msg_bits[8:3];
      store_byte(pos, PAD_MARK);
      for (int w = pos[5:2] + 1; w < 16; w++) blk[w] = '0;
      // no room for the length: spill into a second block
      if (pos >= 6'd56) begin
        md4_compress();
        for (int w = 0; w < 16; w++) blk[w] = '0;
      end
      blk[14] = msg_bits[31:0];
      blk[15] = msg_bits[63:32];
      md4_compress();
      for (int w = 0; w < 4; w++) begin
        e.word = chain[w];
        e.idx = w[1:0];
        e.last = (w == 3);
        digest_expect.push_back(e);
      end
      restart_digest();
    end
  endfunction

  function automatic void push_item(logic [7:0] v, logic has, logic fin);
    byte_item_t it;
    it.data = v;
    it.has = has;
    it.fin = fin;
    pending_bytes.push_back(it);
    if (has || fin) items_queued++;
  endfunction

  task automatic add_message(int len);
    bit empty_end;
    empty_end = (len == 0) || ($urandom_range(0, 3) == 0);
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(0, 7) == 0) push_item(8'($urandom_range(0, 255)), 1'b0, 1'b0);
      push_item(8'($urandom_range(0, 255)), 1'b1, !empty_end && (i == len - 1));
    end
    if (empty_end) push_item(8'($urandom_range(0, 255)), 1'b0, 1'b1);
  endtask

  task automatic wait_idle();
    while (pending_bytes.size() != 0 || in_valid || digest_expect.size() != 0)
      @(posedge clk);
  endtask

  function automatic void report(string field, logic [31:0] exp_v, logic [31:0] act_v);
    errors++;
    $display("%0t: %s mismatch, expected %h actual %h", $time, field, exp_v, act_v);
  endfunction

  // input side: predict on every accepted word
  always @(posedge clk) begin
    if (!rst && in_valid && !in_stall) begin
      digest_absorb(data_byte, has_byte, message_end);
      in_taken = 1'b1;
    end
  end

  // output monitor
  always @(posedge clk) begin : monitor
    digest_out_t e;
    if (!rst && out_valid && !out_stall) begin
      out_taken = 1'b1;
      words_seen++;
      if (digest_expect.size() == 0) begin
        errors++;
        $display("%0t: unexpected digest word, expected none actual %h idx %0d",
                 $time, digest_word, word_index);
      end else begin
        e = digest_expect.pop_front();
        if (digest_word !== e.word) report("digest_word", e.word, digest_word);
        if (word_index !== e.idx) report("word_index", 32'(e.idx), 32'(word_index));
        if (digest_last !== e.last) report("digest_last", 32'(e.last), 32'(digest_last));
      end
    end
  end

  // driver
  always @(negedge clk) begin : drive_in
    byte_item_t it;
    bit free;
    free = !in_valid || in_taken;
    if (in_taken) begin
      in_taken = 1'b0;
      gap_left = draw_pause(calm_in);
    end
    if (!rst && free) begin
      if (gap_left > 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (pending_bytes.size() > 0) begin
        it = pending_bytes.pop_front();
        data_byte <= it.data;
        has_byte <= it.has;
        message_end <= it.fin;
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver stalls, plus one long hold to back the block up into its input
  always @(negedge clk) begin
    if (out_taken) begin
      out_taken = 1'b0;
      stall_left = draw_pause(calm_out);
    end
    if (!hold_done && words_seen >= HOLD_AFTER_WORDS) begin
      hold_done = 1'b1;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if (stall_left > 0 && out_valid) begin
      stall_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  initial begin
    int len;
    restart_digest();
    for (int i = 0; i < 16; i++) blk[i] = '0;

    // empty message, single-byte messages at both byte extremes
    push_item(8'h3c, 1'b0, 1'b1);
    push_item(8'h00, 1'b1, 1'b1);
    push_item(8'hff, 1'b1, 1'b1);
    // "abc" with idle words mixed in, closed by an empty end word
    push_item(8'ha5, 1'b0, 1'b0);
    push_item(8'h61, 1'b1, 1'b0);
    push_item(8'h62, 1'b1, 1'b0);
    push_item(8'h5a, 1'b0, 1'b0);
    push_item(8'h63, 1'b1, 1'b0);
    push_item(8'hc3, 1'b0, 1'b1);
    // alternating bit patterns
    push_item(8'h55, 1'b1, 1'b0);
    push_item(8'haa, 1'b1, 1'b0);
    push_item(8'h0f, 1'b1, 1'b0);
    push_item(8'hf0, 1'b1, 1'b0);
    push_item(8'h80, 1'b1, 1'b1);

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // sender pause: let everything drain before the random part
    wait_idle();

    while (items_queued < ITEM_TARGET) begin
      // bias toward the one/two padding-block boundary and full blocks
      if ($urandom_range(0, 9) < 3) len = $urandom_range(52, 72);
      else len = $urandom_range(0, 10);
      add_message(len);
    end

    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin
    #400000;
    $display("Regression FAIL");
    $finish;
  end

endmodule
